// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the RTL file of the date difference block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge while out of reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed in date difference block");

// Check that an antecedent is followed by a consequent after a fixed delay.
`define ASSERT_DELAY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> ##1 (cons)) \
    else $error("delayed assertion failed in date difference block");

`endif

// ===== hw/rtl/dd_pkg.sv =====
// Package with widths, types and calendar tables of the date difference block.
package dd_pkg;

  localparam int unsigned YearW  = 14;
  localparam int unsigned MonthW = 4;
  localparam int unsigned DayW   = 5;
  localparam int unsigned CountW = 22;
  localparam int unsigned StartW = 9;

  localparam logic [YearW-1:0]  YearMax  = 14'd9999;
  localparam logic [CountW-1:0] DaysYear = 22'd365;
  localparam logic [MonthW-1:0] MonthFeb = 4'd2;
  localparam logic [MonthW-1:0] MonthDec = 4'd12;

  // Validity and day number of one date.
  typedef struct packed {
    logic              ok;
    logic [CountW-1:0] num;
  } day_num_t;

  // Length of a month; 0 for a month code that means nothing.
  function automatic logic [DayW-1:0] month_len(input logic [MonthW-1:0] m,
                                                input logic             leap);
    logic [DayW-1:0] len;
    len = '0;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = '0;
    endcase
    return len;
  endfunction

  // Days in the months before month m of a common year.
  function automatic logic [StartW-1:0] month_start(input logic [MonthW-1:0] m);
    logic [StartW-1:0] s;
    s = '0;
    case (m)
      4'd3:    s = 9'd59;
      4'd4:    s = 9'd90;
      4'd5:    s = 9'd120;
      4'd6:    s = 9'd151;
      4'd7:    s = 9'd181;
      4'd8:    s = 9'd212;
      4'd9:    s = 9'd243;
      4'd10:   s = 9'd273;
      4'd11:   s = 9'd304;
      4'd12:   s = 9'd334;
      4'd2:    s = 9'd31;
      default: s = '0;
    endcase
    return s;
  endfunction

endpackage

// ===== hw/rtl/dd_day_number.sv =====
// Date check and day number of one calendar date.
module dd_day_number (
  input  logic [dd_pkg::YearW-1:0]  year_i,
  input  logic [dd_pkg::MonthW-1:0] month_i,
  input  logic [dd_pkg::DayW-1:0]   day_i,
  output dd_pkg::day_num_t          res_o
);

  logic                       leap;
  logic [dd_pkg::YearW-1:0]   prev_year;
  logic [dd_pkg::CountW-1:0]  prev_ext;
  logic [dd_pkg::CountW-1:0]  year_days;
  logic [dd_pkg::CountW-1:0]  leap_days;
  logic [dd_pkg::CountW-1:0]  extra_day;

  // Leap year when divisible by four, no century rule.
  assign leap = (year_i[1:0] == 2'b00);

  // Check year, month and day ranges.
  assign res_o.ok = (year_i != '0) && (year_i <= dd_pkg::YearMax) &&
                    (month_i != '0) && (month_i <= dd_pkg::MonthDec) &&
                    (day_i != '0) && (day_i <= dd_pkg::month_len(month_i, leap));

  // Sum whole years, leap days, earlier months and the day itself.
  assign prev_year = year_i - dd_pkg::YearW'(1);
  assign prev_ext  = dd_pkg::CountW'(prev_year);
  assign year_days = prev_ext * dd_pkg::DaysYear;
  assign leap_days = dd_pkg::CountW'(prev_year >> 2);
  assign extra_day = dd_pkg::CountW'(leap && (month_i > dd_pkg::MonthFeb));

  assign res_o.num = year_days + leap_days
                   + dd_pkg::CountW'(dd_pkg::month_start(month_i))
                   + dd_pkg::CountW'(day_i) + extra_day;

endmodule

// ===== hw/rtl/date_difference_days.sv =====
// The accepted item is held in the input registers, then the result and done_o in the result registers;
// done_o rises after the edge that follows acceptance, result taken next edge. Throughput: one item per cycle;
// busy stays low, the single compute stage never stalls. The path between the input and result registers holds
// two day-number units and one compare and subtract; the receiver cannot stall and needs none.
// Reset clears the input valid flag and the done flag only; the result and payload registers are not reset.
`include "assert_macros.svh"

module date_difference_days (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start,
  output logic                      busy,
  input  logic [dd_pkg::YearW-1:0]  start_year_i,
  input  logic [dd_pkg::MonthW-1:0] start_month_i,
  input  logic [dd_pkg::DayW-1:0]   start_day_i,
  input  logic [dd_pkg::YearW-1:0]  end_year_i,
  input  logic [dd_pkg::MonthW-1:0] end_month_i,
  input  logic [dd_pkg::DayW-1:0]   end_day_i,
  output logic                      done_o,
  output logic                      dates_valid_o,
  output logic [dd_pkg::CountW-1:0] day_count_o
);

  logic                      in_vld_q;
  logic [dd_pkg::YearW-1:0]  sy_q, ey_q;
  logic [dd_pkg::MonthW-1:0] sm_q, em_q;
  logic [dd_pkg::DayW-1:0]   sd_q, ed_q;

  dd_pkg::day_num_t          start_num, end_num;
  logic                      valid_d, valid_q;
  logic [dd_pkg::CountW-1:0] count_d, count_q;
  logic                      done_q;

  // Never hold off an item.
  assign busy = 1'b0;

  // Capture the accepted item.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      sy_q <= start_year_i;
      sm_q <= start_month_i;
      sd_q <= start_day_i;
      ey_q <= end_year_i;
      em_q <= end_month_i;
      ed_q <= end_day_i;
    end
  end

  // Day numbers of both dates.
  dd_day_number u_start_num (
    .year_i  (sy_q),
    .month_i (sm_q),
    .day_i   (sd_q),
    .res_o   (start_num)
  );

  dd_day_number u_end_num (
    .year_i  (ey_q),
    .month_i (em_q),
    .day_i   (ed_q),
    .res_o   (end_num)
  );

  // Drop pairs with a bad date or the start after the end.
  always_comb begin
    valid_d = start_num.ok && end_num.ok && (start_num.num <= end_num.num);
    count_d = valid_d ? (end_num.num - start_num.num) : '0;
  end

  // Register the result and its strobe.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= in_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_vld_q) begin
      valid_q <= valid_d;
      count_q <= count_d;
    end
  end

  assign done_o        = done_q;
  assign dates_valid_o = valid_q;
  assign day_count_o   = count_q;

  // An invalid pair always reports a zero count.
  `ASSERT_CLK(a_invalid_zero, clk_i, rst_ni, !done_o || dates_valid_o || (day_count_o == '0))
  // Every accepted item gives a result through the input and result registers.
  `ASSERT_DELAY(a_item_result, clk_i, rst_ni, start && !busy, done_o)
  // No result appears without an accepted item.
  `ASSERT_DELAY(a_no_spurious, clk_i, rst_ni, !start, !done_o)

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for the date_difference_days block.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [dd_pkg::YearW-1:0]  y;
    logic [dd_pkg::MonthW-1:0] m;
    logic [dd_pkg::DayW-1:0]   d;
  } cal_date_t;

  typedef struct packed {
    cal_date_t from_d;
    cal_date_t to_d;
  } span_req_t;

  typedef struct packed {
    logic                      ok;
    logic [dd_pkg::CountW-1:0] days;
  } span_res_t;

  localparam int unsigned PhaseCnt   = 4;
  localparam int unsigned PhaseItems = 112;
  localparam int unsigned MaxReports = 10;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  // Driven item and handshake; known from time zero.
  logic      start    = 1'b0;
  span_req_t drive_req = '0;

  logic                      busy;
  logic                      done_o;
  logic                      dates_valid_o;
  logic [dd_pkg::CountW-1:0] day_count_o;

  span_req_t pending_dates[$];
  span_res_t expected_spans[$];

  int unsigned idle_pct = 0;
  logic        hold_off = 1'b0;
  int unsigned err_cnt  = 0;

  date_difference_days dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .start_year_i  (drive_req.from_d.y),
    .start_month_i (drive_req.from_d.m),
    .start_day_i   (drive_req.from_d.d),
    .end_year_i    (drive_req.to_d.y),
    .end_month_i   (drive_req.to_d.m),
    .end_day_i     (drive_req.to_d.d),
    .done_o        (done_o),
    .dates_valid_o (dates_valid_o),
    .day_count_o   (day_count_o)
  );

  // Calendar arithmetic: leap year is any year divisible by four.
  function automatic bit is_leap_year(input int unsigned y);
    return (y % 4) == 0;
  endfunction

  function automatic int unsigned days_in_month(input int unsigned m, input bit leap);
    int unsigned len;
    case (m)
      1, 3, 5, 7, 8, 10, 12: len = 31;
      4, 6, 9, 11:           len = 30;
      2:                     len = leap ? 29 : 28;
      default:               len = 0;
    endcase
    return len;
  endfunction

  function automatic bit date_legal(input cal_date_t dt);
    if (dt.y < 1 || dt.y > 9999 || dt.m < 1 || dt.m > 12 || dt.d < 1) return 1'b0;
    return dt.d <= days_in_month(dt.m, is_leap_year(dt.y));
  endfunction

  // Day number counted from 1 Jan of year 1; date must be legal.
  function automatic int unsigned ordinal_day(input cal_date_t dt);
    int unsigned p;
    int unsigned n;
    p = dt.y - 1;
    n = p * 365 + p / 4 + dt.d;
    for (int unsigned k = 1; k < dt.m; k++) n += days_in_month(k, is_leap_year(dt.y));
    return n;
  endfunction

  function automatic span_res_t predict_span(input span_req_t r);
    span_res_t   res;
    int unsigned a;
    int unsigned b;
    res = '0;
    if (!date_legal(r.from_d) || !date_legal(r.to_d)) return res;
    a = ordinal_day(r.from_d);
    b = ordinal_day(r.to_d);
    if (a > b) return res;
    res.ok   = 1'b1;
    res.days = dd_pkg::CountW'(b - a);
    return res;
  endfunction

  function automatic cal_date_t mk_date(input int unsigned y, input int unsigned m,
                                        input int unsigned d);
    cal_date_t dt;
    dt.y = dd_pkg::YearW'(y);
    dt.m = dd_pkg::MonthW'(m);
    dt.d = dd_pkg::DayW'(d);
    return dt;
  endfunction

  // Legal date; years sometimes pinned to a given year.
  function automatic cal_date_t rand_legal_date(input int unsigned near_y);
    int unsigned y;
    int unsigned m;
    if (near_y != 0 && $urandom_range(1) == 1) y = near_y;
    else if ($urandom_range(3) == 0) y = $urandom_range(1, 40);
    else y = $urandom_range(1, 9999);
    m = $urandom_range(1, 12);
    return mk_date(y, m, $urandom_range(1, days_in_month(m, is_leap_year(y))));
  endfunction

  function automatic cal_date_t rand_raw_date();
    return mk_date($urandom_range(16383), $urandom_range(15), $urandom_range(31));
  endfunction

  function automatic span_req_t rand_span();
    span_req_t r;
    cal_date_t tmp;
    int unsigned k;
    k = $urandom_range(99);
    r.from_d = rand_legal_date(0);
    r.to_d   = rand_legal_date(r.from_d.y);
    // Order the legal pair: start no later than end
    if (ordinal_day(r.from_d) > ordinal_day(r.to_d)) begin
      tmp = r.from_d;
      r.from_d = r.to_d;
      r.to_d = tmp;
    end
    if (k < 60) begin
      return r;
    end else if (k < 70) begin
      // Swap to a start later than end (unless equal)
      tmp = r.from_d;
      r.from_d = r.to_d;
      r.to_d = tmp;
    end else if (k < 78) begin
      r.to_d = r.from_d;
    end else if (k < 90) begin
      // Break one field of an otherwise legal pair
      case ($urandom_range(5))
        0: r.from_d.y = dd_pkg::YearW'($urandom_range(16383));
        1: r.from_d.m = dd_pkg::MonthW'($urandom_range(15));
        2: r.from_d.d = dd_pkg::DayW'($urandom_range(31));
        3: r.to_d.y   = dd_pkg::YearW'($urandom_range(16383));
        4: r.to_d.m   = dd_pkg::MonthW'($urandom_range(15));
        default: r.to_d.d = dd_pkg::DayW'($urandom_range(31));
      endcase
    end else begin
      r.from_d = rand_raw_date();
      r.to_d   = rand_raw_date();
    end
    return r;
  endfunction

  task automatic queue_pair(input cal_date_t a, input cal_date_t b);
    span_req_t r;
    r.from_d = a;
    r.to_d   = b;
    pending_dates.push_back(r);
  endtask

  // Clock
  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Driver: record accepted items, then present the next one or idle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start     <= 1'b0;
      drive_req <= '0;
    end else begin
      if (start && !busy) begin
        expected_spans.push_back(predict_span(drive_req));
      end
      if (!start || !busy) begin
        if (pending_dates.size() != 0 && !hold_off && $urandom_range(99) >= idle_pct) begin
          start     <= 1'b1;
          drive_req <= pending_dates.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_spans.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MaxReports)
          $display("ERROR: unexpected result valid=%0b count=%0d", dates_valid_o, day_count_o);
      end else begin
        span_res_t exp_r;
        exp_r = expected_spans.pop_front();
        if (exp_r.ok !== dates_valid_o || exp_r.days !== day_count_o) begin
          err_cnt++;
          if (err_cnt <= MaxReports)
            $display("ERROR: exp valid=%0b count=%0d, got valid=%0b count=%0d",
                     exp_r.ok, exp_r.days, dates_valid_o, day_count_o);
        end
      end
    end
  end

  // Stimulus, phases and end of run
  initial begin
    int unsigned phase_idle[PhaseCnt];
    phase_idle[0] = 0;
    phase_idle[1] = 47;
    phase_idle[2] = 0;
    phase_idle[3] = 34;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed corners: extremes, equal dates and each invalid case
    queue_pair(mk_date(1, 1, 1), mk_date(1, 1, 1));
    queue_pair(mk_date(1, 1, 1), mk_date(9999, 12, 31));
    queue_pair(mk_date(2023, 6, 15), mk_date(2023, 6, 15));
    queue_pair(mk_date(2024, 2, 29), mk_date(2025, 3, 1));
    queue_pair(mk_date(1900, 2, 29), mk_date(1900, 3, 1));
    queue_pair(mk_date(2023, 2, 29), mk_date(2024, 1, 1));
    queue_pair(mk_date(2023, 1, 1), mk_date(2023, 2, 29));
    queue_pair(mk_date(2020, 1, 31), mk_date(2020, 12, 31));
    queue_pair(mk_date(2020, 0, 10), mk_date(2021, 1, 1));
    queue_pair(mk_date(2020, 1, 10), mk_date(2021, 13, 1));
    queue_pair(mk_date(2020, 15, 10), mk_date(2021, 1, 1));
    queue_pair(mk_date(2020, 1, 0), mk_date(2021, 1, 1));
    queue_pair(mk_date(2020, 4, 31), mk_date(2021, 1, 1));
    queue_pair(mk_date(2020, 1, 1), mk_date(2021, 6, 31));
    queue_pair(mk_date(0, 1, 1), mk_date(5, 1, 1));
    queue_pair(mk_date(1, 1, 1), mk_date(10000, 1, 1));
    queue_pair(mk_date(16383, 15, 31), mk_date(16383, 15, 31));
    queue_pair(mk_date(2001, 1, 1), mk_date(2000, 12, 31));
    queue_pair(mk_date(2000, 5, 1), mk_date(2000, 4, 30));
    queue_pair(mk_date(2000, 5, 2), mk_date(2000, 5, 1));
    queue_pair(mk_date(1999, 12, 31), mk_date(2000, 1, 1));
    queue_pair(mk_date(9999, 12, 31), mk_date(9999, 12, 31));
    queue_pair(mk_date(4, 2, 28), mk_date(4, 3, 1));

    for (int unsigned ph = 0; ph < PhaseCnt; ph++) begin
      idle_pct = phase_idle[ph];
      for (int unsigned i = 0; i < PhaseItems; i++) pending_dates.push_back(rand_span());
      while (pending_dates.size() != 0) @(posedge clk_i);
      // Hold the sender until every outstanding result has come back
      hold_off = 1'b1;
      while (start || expected_spans.size() != 0) @(posedge clk_i);
      hold_off = 1'b0;
    end

    // Drain: allow the pipeline latency to flush stray results
    repeat (8) @(posedge clk_i);
    if (expected_spans.size() != 0) begin
      err_cnt += expected_spans.size();
      $display("ERROR: %0d results never arrived", expected_spans.size());
    end
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
